// ===== sv/csm_pkg.sv =====
// Shared widths, step-unit operation codes and step result type for the clock ratio block.
`timescale 1ns / 1ps

package csm_pkg;

  localparam int FreqW  = 62;
  localparam int ShiftW = 7;
  localparam int MulW   = 32;
  localparam int WordW  = 32;
  localparam int CntW   = 5;

  // Operation of the shared step unit
  typedef enum logic [1:0] {
    OP_BASE,
    OP_TGT,
    OP_DIV
  } op_t;

  // One step of the shared unit: updated operands, loop-continue flag, quotient bit
  typedef struct packed {
    logic [FreqW-1:0] tgt;
    logic [FreqW-1:0] base;
    logic             more;
    logic             qbit;
  } step_t;

endpackage

// ===== sv/csm_in_if.sv =====
// Input channel: target and source frequencies with valid/ready handshake.
`timescale 1ns / 1ps

interface csm_in_if;
  logic                       valid;
  logic                       ready;
  logic [csm_pkg::FreqW-1:0]  target_hz;
  logic [csm_pkg::FreqW-1:0]  source_hz;

  modport source (output valid, output target_hz, output source_hz, input ready);
  modport sink   (input valid, input target_hz, input source_hz, output ready);
endinterface

// ===== sv/csm_out_if.sv =====
// Output channel: shift, multiplier and bad-input flag with valid/ready handshake.
`timescale 1ns / 1ps

interface csm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [csm_pkg::ShiftW-1:0] shift;
  logic [csm_pkg::MulW-1:0]          multiplier;
  logic                              bad_input;

  modport source (output valid, output shift, output multiplier, output bad_input, input ready);
  modport sink   (input valid, input shift, input multiplier, input bad_input, output ready);
endinterface

// ===== sv/clock_ratio_shift_multiplier.sv =====
// Top level: sequencer and registers around the shared step unit.
//
//   channel | dir | fields
//   freq    | in  | target_hz[61:0], source_hz[61:0]
//   scale   | out | shift[6:0] (signed), multiplier[31:0], bad_input
//
// Each normalization step and each quotient bit is one pass through the step unit.
// A zero frequency skips all work and goes from idle straight to the output state.
// freq.ready is high only while the sequencer is idle; a finished result waits in the output
// register, and the next item may start meanwhile but holds before its final load.
// Reset (synchronous) returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps

module clock_ratio_shift_multiplier (
  input logic        clk,
  input logic        rst,
  csm_in_if.sink     freq,
  csm_out_if.source  scale
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_TGT,
    S_DIV,
    S_OUT
  } state_t;

  state_t                      state;
  logic [csm_pkg::FreqW-1:0]   tgt;
  logic [csm_pkg::FreqW-1:0]   base;
  logic [csm_pkg::ShiftW-1:0]  sh;
  logic [csm_pkg::MulW-1:0]    quot;
  logic [csm_pkg::CntW-1:0]    cnt;
  logic                        bad;
  logic                        ovalid;
  logic [csm_pkg::ShiftW-1:0]  shift_q;
  logic [csm_pkg::MulW-1:0]    mul_q;
  logic                        bad_q;

  csm_pkg::op_t   op;
  csm_pkg::step_t step;
  logic           in_zero;
  logic           slot_free;

  assign in_zero   = (freq.target_hz == '0) || (freq.source_hz == '0);
  assign slot_free = !ovalid || scale.ready;

  always_comb begin
    case (state)
      S_BASE:  op = csm_pkg::OP_BASE;
      S_TGT:   op = csm_pkg::OP_TGT;
      default: op = csm_pkg::OP_DIV;
    endcase
  end

  csm_step_unit u_step (
    .op   (op),
    .tgt  (tgt),
    .base (base),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (ovalid && scale.ready && (state != S_OUT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (freq.valid) begin
            tgt   <= freq.target_hz;
            base  <= freq.source_hz;
            sh    <= '0;
            quot  <= '0;
            cnt   <= '0;
            bad   <= in_zero;
            state <= in_zero ? S_OUT : S_BASE;
          end
        end
        S_BASE: begin
          if (step.more) begin
            base <= step.base;
            sh   <= sh - 1'b1;
          end else begin
            state <= S_TGT;
          end
        end
        S_TGT: begin
          if (step.more) begin
            tgt  <= step.tgt;
            base <= step.base;
            sh   <= sh + 1'b1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          tgt  <= step.tgt;
          quot <= {quot[csm_pkg::MulW-2:0], step.qbit};
          cnt  <= cnt + 1'b1;
          if (cnt == {csm_pkg::CntW{1'b1}}) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (slot_free) begin
            shift_q <= sh;
            mul_q   <= quot;
            bad_q   <= bad;
            ovalid  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign freq.ready       = (state == S_IDLE);
  assign scale.valid      = ovalid;
  assign scale.shift      = shift_q;
  assign scale.multiplier = mul_q;
  assign scale.bad_input  = bad_q;

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    scale.valid && scale.bad_input |-> scale.shift == '0 && scale.multiplier == '0)
    else $error("bad input result carries nonzero fields");

  a_zero_skip: assert property (@(posedge clk) disable iff (rst)
    freq.valid && freq.ready && in_zero |=> state == S_OUT && bad)
    else $error("zero frequency did not go straight to output");

  a_base_word: assert property (@(posedge clk) disable iff (rst)
    state == S_TGT |-> base[csm_pkg::FreqW-1:csm_pkg::WordW] == '0)
    else $error("base wider than a word after halving");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |->
      tgt < {{(csm_pkg::FreqW-csm_pkg::WordW){1'b0}}, base[csm_pkg::WordW-1:0]})
    else $error("division remainder not below divisor");
`endif

endmodule

// ===== sv/csm_step_unit.sv =====
// Shared step unit: one normalization shift or one restoring division step per cycle.
`timescale 1ns / 1ps

module csm_step_unit (
  input  csm_pkg::op_t               op,
  input  logic [csm_pkg::FreqW-1:0]  tgt,
  input  logic [csm_pkg::FreqW-1:0]  base,
  output csm_pkg::step_t             step
);

  logic [csm_pkg::WordW-1:0] b32;
  logic                      tgt_wide;
  logic [csm_pkg::WordW:0]   rem2;
  logic [csm_pkg::WordW:0]   diff;

  assign b32      = base[csm_pkg::WordW-1:0];
  assign tgt_wide = (tgt[csm_pkg::FreqW-1:csm_pkg::WordW] != '0);
  assign rem2     = {tgt[csm_pkg::WordW-1:0], 1'b0};
  assign diff     = rem2 - {1'b0, b32};

  always_comb begin
    step.tgt  = tgt;
    step.base = base;
    step.more = 1'b0;
    step.qbit = 1'b0;
    case (op)
      csm_pkg::OP_BASE: begin
        // halve base while it exceeds twice the target or is wider than a word
        step.more = ({1'b0, base} > {tgt, 1'b0}) ||
                    (base[csm_pkg::FreqW-1:csm_pkg::WordW] != '0);
        step.base = base >> 1;
      end
      csm_pkg::OP_TGT: begin
        step.more = ({{(csm_pkg::FreqW-csm_pkg::WordW){1'b0}}, b32} <= tgt) || tgt_wide;
        if (tgt_wide || b32[csm_pkg::WordW-1]) begin
          step.tgt = tgt >> 1;
        end else begin
          step.base = {{(csm_pkg::FreqW-csm_pkg::WordW){1'b0}}, b32 << 1};
        end
      end
      csm_pkg::OP_DIV: begin
        // remainder lives in the target register
        step.more = 1'b1;
        if (rem2 >= {1'b0, b32}) begin
          step.qbit = 1'b1;
          step.tgt  = {{(csm_pkg::FreqW-csm_pkg::WordW-1){1'b0}}, diff};
        end else begin
          step.tgt  = {{(csm_pkg::FreqW-csm_pkg::WordW-1){1'b0}}, rem2};
        end
      end
      default: begin
        step.more = 1'b0;
      end
    endcase
  end

endmodule
